// ===== rtl/core/tmpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpr_pkg: shared types and constants for the threshold mask rewriter
// Window size, rewrite rule tables, run descriptor and the greedy decision.
// ----------------------------------------------------------------------------
package tmpr_pkg;

    localparam int WINDOW  = 6;
    localparam int CNT_W   = 3;
    localparam int NUM_PAT = 7;
    localparam int SMP_W   = 16;

    localparam logic [SMP_W-1:0] THRESH_RESET = 16'd369;

    // bit i of a pattern is the mark at offset i from the head
    localparam logic [CNT_W-1:0]  PAT_LEN  [NUM_PAT] = '{
        3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6
    };
    localparam logic [WINDOW-1:0] PAT_BITS [NUM_PAT] = '{
        6'h0D, 6'h0B, 6'h19, 6'h13, 6'h0A, 6'h04, 6'h0C
    };
    localparam logic              PAT_FILL [NUM_PAT] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0
    };

    // one decision: len marks of value fill
    typedef struct packed {
        logic             fill;
        logic [CNT_W-1:0] len;
        logic             last;
    } t_run;

    typedef struct packed {
        logic             fill;
        logic [CNT_W-1:0] len;
    } t_decision;

    // shortest matching prefix wins; no match passes the head mark
    function automatic t_decision tmpr_decide(
        input logic [WINDOW-1:0] marks,
        input logic [CNT_W-1:0]  avail
    );
        t_decision       d;
        logic [WINDOW:0] mask;
        d.fill = marks[0];
        d.len  = CNT_W'(1);
        for (int len = WINDOW; len >= 1; len--) begin
            mask = (WINDOW+1)'((1 << len) - 1);
            for (int k = 0; k < NUM_PAT; k++) begin
                if ((int'(PAT_LEN[k]) == len) && (CNT_W'(len) <= avail) &&
                    ((marks & mask[WINDOW-1:0]) == PAT_BITS[k])) begin
                    d.fill = PAT_FILL[k];
                    d.len  = CNT_W'(len);
                end
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/tmpr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpr_front: sample classification and pattern decision
// Thresholds samples into marks, keeps the six-mark window and pushes one
// run per decision; after the last sample it flushes the window.
// ----------------------------------------------------------------------------
module tmpr_front
    import tmpr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SMP_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SMP_W-1:0] i_sample,
    input  logic             i_last,
    output logic             o_push,
    output t_run             o_run,
    input  logic             i_full
);

    logic [SMP_W-1:0]  r_thresh;
    logic [WINDOW-1:0] r_marks, n_marks;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_flush, n_flush;
    logic              do_dec, accept, mark;
    t_decision         dec;
    logic [CNT_W-1:0]  remain;

    always_comb begin
        dec     = tmpr_decide(r_marks, r_count);
        remain  = r_count - dec.len;
        do_dec  = r_flush ? (r_count != '0) : (r_count == CNT_W'(WINDOW));
        o_push  = do_dec && !i_full;
        o_ready = !r_flush && (r_count != CNT_W'(WINDOW));
        accept  = i_valid && o_ready;
        mark    = i_sample > r_thresh;
        o_run.fill = dec.fill;
        o_run.len  = dec.len;
        o_run.last = r_flush && (remain == '0);
    end

    always_comb begin
        n_marks = r_marks;
        n_count = r_count;
        n_flush = r_flush;
        if (o_push) begin
            n_marks = r_marks >> dec.len;
            n_count = remain;
            if (remain == '0) begin
                n_flush = 1'b0;
            end
        end else if (accept) begin
            n_marks = r_marks | (WINDOW'(mark) << r_count);
            n_count = r_count + CNT_W'(1);
            n_flush = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_marks  <= '0;
            r_count  <= '0;
            r_flush  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            r_marks <= n_marks;
            r_count <= n_count;
            r_flush <= n_flush;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("window count out of range");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_run.last) |=> (r_count == '0 && !r_flush))
        else $error("flush did not empty the window");

endmodule

// ===== rtl/core/tmpr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpr_queue: run descriptor queue
// Small FIFO between the decision front and the mark emitter.
// ----------------------------------------------------------------------------
module tmpr_queue
    import tmpr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_run o_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    t_run             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_Q-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = r_cnt == CNT_Q'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_run   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_Q'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_Q'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");

endmodule

// ===== rtl/core/tmpr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpr_back: mark emitter
// Expands each run into single marks through a registered output stage.
// ----------------------------------------------------------------------------
module tmpr_back
    import tmpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_run i_run,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic o_mark,
    output logic o_last
);

    logic [CNT_W-1:0] r_left, n_left;
    logic             r_fill, n_fill;
    logic             r_last, n_last;
    logic             r_ovalid, n_ovalid;
    logic             r_omark, n_omark;
    logic             r_olast, n_olast;
    logic             can_load, emit;

    always_comb begin
        can_load = !r_ovalid || i_ready;
        emit     = can_load && (r_left != '0);
        o_pop    = i_valid && ((r_left == '0) || (emit && (r_left == CNT_W'(1))));
        n_left   = r_left;
        n_fill   = r_fill;
        n_last   = r_last;
        n_ovalid = r_ovalid;
        n_omark  = r_omark;
        n_olast  = r_olast;
        if (emit) begin
            n_left   = r_left - CNT_W'(1);
            n_ovalid = 1'b1;
            n_omark  = r_fill;
            n_olast  = r_last && (r_left == CNT_W'(1));
        end else if (can_load) begin
            n_ovalid = 1'b0;
        end
        if (o_pop) begin
            n_left = i_run.len;
            n_fill = i_run.fill;
            n_last = i_run.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill  <= n_fill;
        r_last  <= n_last;
        r_omark <= n_omark;
        r_olast <= n_olast;
    end

    assign o_valid = r_ovalid;
    assign o_mark  = r_omark;
    assign o_last  = r_olast;

endmodule

// ===== rtl/core/threshold_mask_pattern_rewriter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_mask_pattern_rewriter_top: threshold mask pattern rewriter
// Marks Q4.12 samples mobile or fixed and smooths the marks with greedy
// pattern rewrites over a six-mark window.
//
//   channel  dir  payload                          request done when
//   s_axis   in   tdata[15:0] sample, tlast last   tvalid & tready
//   m_axis   out  tdata[0] mark, tlast last mark   tvalid & tready
//   cfg      in   i_cfg_wdata threshold            i_cfg_we
//
// A sample is taken while the window has room; a full window decides first.
// The last sample flushes the window, one decision per cycle unless the queue
// is full. Marks leave the output register one per cycle unless tready is low.
// Synchronous active-low reset empties the window; threshold resets to 369.
// Front and back stall independently across the run queue.
// ----------------------------------------------------------------------------
module threshold_mask_pattern_rewriter_top
    import tmpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] mark, [7:1] zero
    output logic        m_axis_tlast
);

    logic q_push, q_full, q_pop, q_valid, mark;
    t_run f_run, q_run;

    tmpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (q_push),
        .o_run       (f_run),
        .i_full      (q_full)
    );

    tmpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (f_run),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_run   (q_run)
    );

    tmpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_run   (q_run),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_mark  (mark),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, mark};

endmodule

// ===== tb/threshold_mask_pattern_rewriter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_mask_pattern_rewriter_top_tb: self-checking bench for the rewriter
// Streams sample runs through the slave port and rewrites the marks in a
// scoreboard that tracks the six-mark window. Every mark taken from the
// master port is compared in order. Runs cover the threshold extremes and
// each rewrite pattern, then random runs with idle bursts on both ports and
// one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module threshold_mask_pattern_rewriter_top_tb;

    localparam int CLK_LIMIT = 200000;
    localparam int WIN       = 6;

    typedef struct packed {
        logic mark;
        logic last;
    } t_mark_rec;

    class mark_scoreboard;
        string       rules [7];
        logic [15:0] threshold;
        logic [5:0]  window_marks;
        int          window_count;
        t_mark_rec   predicted_marks [$];
        int          errors;

        function new();
            rules = '{"M.MM", "MM.M", "M..MM", "MM..M", ".M.M.", "..M..", "..MM.."};
            threshold    = 16'd369;
            window_marks = '0;
            window_count = 0;
            errors       = 0;
        endfunction

        function void set_threshold(input logic [15:0] value);
            threshold = value;
        endfunction

        function int outstanding();
            return predicted_marks.size();
        endfunction

        function bit rule_fits(input int k, input int len);
            if (rules[k].len() != len) return 1'b0;
            for (int i = 0; i < len; i++) begin
                if (window_marks[i] != (rules[k][i] == "M")) return 1'b0;
            end
            return 1'b1;
        endfunction

        // shortest matching prefix wins; otherwise the head mark passes
        function void rewrite_head(inout int emitted);
            logic      fill;
            int        taken;
            bit        hit;
            t_mark_rec rec;
            fill  = window_marks[0];
            taken = 1;
            hit   = 1'b0;
            for (int len = 1; len <= window_count && len <= WIN && !hit; len++) begin
                for (int k = 0; k < 7 && !hit; k++) begin
                    if (rule_fits(k, len)) begin
                        hit   = 1'b1;
                        taken = len;
                        fill  = (k < 4);
                    end
                end
            end
            for (int i = 0; i < taken && emitted < WIN; i++) begin
                rec.mark = fill;
                rec.last = 1'b0;
                predicted_marks.insert(predicted_marks.size(), rec);
                emitted++;
            end
            window_marks = window_marks >> taken;
            window_count -= taken;
        endfunction

        function void note_sample(input logic [15:0] smp, input logic lst);
            int emitted;
            emitted = 0;
            if (window_count >= WIN) rewrite_head(emitted);
            window_marks[window_count] = (smp > threshold);
            window_count++;
            if (window_count >= WIN) rewrite_head(emitted);
            if (lst) begin
                while (window_count > 0 && emitted < WIN) rewrite_head(emitted);
                window_marks = '0;
                window_count = 0;
                if (emitted > 0) predicted_marks[predicted_marks.size()-1].last = 1'b1;
            end
        endfunction

        function void check_mark(input logic [7:0] data, input logic lst);
            t_mark_rec want;
            if (predicted_marks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected mark: data %02h last %0d", data, lst);
                return;
            end
            want = predicted_marks.pop_front();
            if (data !== {7'd0, want.mark} || lst !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("mark mismatch: expected data %02h last %0d, got data %02h last %0d",
                             {7'd0, want.mark}, want.last, data, lst);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    mark_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_req;
    bit             tail_last;
    int             items_sent;
    int             cycles;

    threshold_mask_pattern_rewriter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CLK_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_mark(m_axis_tdata, m_axis_tlast);
    end

    // output side: random stalls, plus one long hold on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (80) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (i_rst_n && $urandom_range(0, 99) < recv_idle_pct) begin
                m_axis_tready = 1'b0;
                gap = $urandom_range(1, 5);
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = i_rst_n;
            end
        end
    end

    function automatic logic [15:0] sample_for(input bit mobile);
        logic [15:0] thr;
        thr = sb.threshold;
        if (mobile && thr != 16'hFFFF) begin
            if ($urandom_range(0, 3) == 0) return thr + 16'd1;
            return 16'($urandom_range(65535, int'(thr) + 1));
        end
        if (mobile) return 16'hFFFF;
        if ($urandom_range(0, 3) == 0) return thr;
        return 16'($urandom_range(int'(thr), 0));
    endfunction

    task automatic send_sample(input logic [15:0] smp, input logic lst);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tlast  = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(smp, lst);
        items_sent++;
        tail_last = lst;
    endtask

    task automatic send_marks(input string marks);
        for (int i = 0; i < marks.len(); i++)
            send_sample(sample_for(marks[i] == "M"), i == marks.len() - 1);
    endtask

    // well-formed run: pattern chunks (sometimes cut short) and loose marks
    task automatic send_run();
        bit    q [$];
        string pat;
        int    target;
        int    cut;
        target = $urandom_range(1, 20);
        while (q.size() < target) begin
            if ($urandom_range(0, 1)) begin
                pat = sb.rules[$urandom_range(0, 6)];
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, pat.len()) : pat.len();
                for (int i = 0; i < cut; i++) q.insert(q.size(), bit'(pat[i] == "M"));
            end else begin
                q.insert(q.size(), bit'($urandom_range(0, 1)));
            end
        end
        for (int i = 0; i < q.size(); i++)
            send_sample(sample_for(q[i]), i == q.size() - 1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) send_sample(16'($urandom()), $urandom_range(0, 9) == 0);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_threshold(value);
    endtask

    task automatic run_random(input int n_items, input bit quiet);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 5);
                recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 5);
            end
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_run();
        end
        if (!tail_last) send_sample(16'($urandom()), 1'b1);
        drain();
    endtask

    initial begin
        sb            = new();
        cycles        = 0;
        items_sent    = 0;
        tail_last     = 1'b1;
        hold_req      = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 30;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every rewrite, lone sample, short flush
        write_threshold(16'd369);
        send_sample(16'hFFFF, 1'b1);
        send_marks("MM..M.M.M.MM.M..M..");
        send_marks("M..MM..MM..");
        send_marks("M.MM");
        drain();

        write_threshold(16'h0000);
        run_random(40, 1'b0);

        write_threshold(16'hFFFF);
        run_random(30, 1'b0);

        write_threshold(16'($urandom()));
        hold_req = 1'b1;
        send_idle_pct = 0;
        run_random(45, 1'b0);

        write_threshold(16'($urandom_range(0, 1023)));
        run_random(45, 1'b0);

        write_threshold(16'($urandom()));
        run_random(45, 1'b0);

        write_threshold(16'd369);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(50, 1'b1);

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== threshold_mask_pattern_rewriter_top.f =====
rtl/core/tmpr_pkg.sv
rtl/core/tmpr_front.sv
rtl/core/tmpr_queue.sv
rtl/core/tmpr_back.sv
rtl/core/threshold_mask_pattern_rewriter_top.sv
tb/threshold_mask_pattern_rewriter_top_tb.sv
